[rtl/rgbpw_pkg.sv]
// ----------------------------------------------------------------------------
// rgbpw_pkg
// Shared types and display-bus command codes for the RGB565 pixel writer.
// ----------------------------------------------------------------------------
package rgbpw_pkg;

   localparam logic [15:0] CMD_COL_ADDR  = 16'h002A;
   localparam logic [15:0] CMD_ROW_ADDR  = 16'h002B;
   localparam logic [15:0] CMD_MEM_WRITE = 16'h002C;

   localparam logic [1:0] REG_START_X = 2'd0;
   localparam logic [1:0] REG_START_Y = 2'd1;
   localparam logic [1:0] REG_END_X   = 2'd2;
   localparam logic [1:0] REG_END_Y   = 2'd3;

   localparam logic [15:0] PANEL_X_LIMIT = 16'd480;
   localparam logic [15:0] PANEL_Y_LIMIT = 16'd320;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] colour;
   } pixel_type;

endpackage

[rtl/rgbpw_word_serializer.sv]
// ----------------------------------------------------------------------------
// rgbpw_word_serializer
// Holds one converted pixel and plays out its twelve display-bus words through
// a registered output stage.
// ----------------------------------------------------------------------------
module rgbpw_word_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  rgbpw_pkg::pixel_type load_pixel,
   output logic                 load_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_command,
   output logic [15:0]          rsp_bus_value,
   output logic                 rsp_last
);

   localparam logic [3:0] SEQ_COL_CMD = 4'd0;
   localparam logic [3:0] SEQ_XH_0    = 4'd1;
   localparam logic [3:0] SEQ_XL_0    = 4'd2;
   localparam logic [3:0] SEQ_XH_1    = 4'd3;
   localparam logic [3:0] SEQ_XL_1    = 4'd4;
   localparam logic [3:0] SEQ_ROW_CMD = 4'd5;
   localparam logic [3:0] SEQ_YH_0    = 4'd6;
   localparam logic [3:0] SEQ_YL_0    = 4'd7;
   localparam logic [3:0] SEQ_YH_1    = 4'd8;
   localparam logic [3:0] SEQ_YL_1    = 4'd9;
   localparam logic [3:0] SEQ_MEM_CMD = 4'd10;
   localparam logic [3:0] SEQ_COLOUR  = 4'd11;

   logic                 pix_valid_ff, pix_valid_in;
   rgbpw_pkg::pixel_type pix_ff;
   logic [3:0]           idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_cmd_ff;
   logic [15:0]          rsp_value_ff;
   logic                 rsp_last_ff;

   logic                 out_load, pix_take, pix_done, load_take;
   logic                 word_cmd, word_last;
   logic [15:0]          word_value;

   always_comb begin
      out_load   = !rsp_valid_ff || rsp_ready;
      pix_take   = pix_valid_ff && out_load;
      pix_done   = pix_take && (idx_ff == SEQ_COLOUR);
      load_ready = !pix_valid_ff || pix_done;
      load_take  = load_valid && load_ready;

      pix_valid_in = pix_valid_ff;
      idx_in       = idx_ff;
      if (load_take) begin
         pix_valid_in = 1'b1;
         idx_in       = SEQ_COL_CMD;
      end else if (pix_done) begin
         pix_valid_in = 1'b0;
      end else if (pix_take) begin
         idx_in = idx_ff + 4'd1;
      end

      rsp_valid_in = out_load ? pix_valid_ff : rsp_valid_ff;
   end

   always_comb begin
      word_cmd   = 1'b0;
      word_last  = 1'b0;
      word_value = 16'h0000;
      case (idx_ff)
         SEQ_COL_CMD: begin
            word_cmd   = 1'b1;
            word_value = rgbpw_pkg::CMD_COL_ADDR;
         end
         SEQ_XH_0, SEQ_XH_1: begin
            word_value = {8'h00, pix_ff.x[15:8]};
         end
         SEQ_XL_0, SEQ_XL_1: begin
            word_value = {8'h00, pix_ff.x[7:0]};
         end
         SEQ_ROW_CMD: begin
            word_cmd   = 1'b1;
            word_value = rgbpw_pkg::CMD_ROW_ADDR;
         end
         SEQ_YH_0, SEQ_YH_1: begin
            word_value = {8'h00, pix_ff.y[15:8]};
         end
         SEQ_YL_0, SEQ_YL_1: begin
            word_value = {8'h00, pix_ff.y[7:0]};
         end
         SEQ_MEM_CMD: begin
            word_cmd   = 1'b1;
            word_value = rgbpw_pkg::CMD_MEM_WRITE;
         end
         SEQ_COLOUR: begin
            word_last  = 1'b1;
            word_value = pix_ff.colour;
         end
         default: begin
            word_value = 16'h0000;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         idx_ff       <= SEQ_COL_CMD;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_take) begin
         pix_ff <= load_pixel;
      end
      if (pix_take) begin
         rsp_cmd_ff   <= word_cmd;
         rsp_value_ff <= word_value;
         rsp_last_ff  <= word_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_command = rsp_cmd_ff;
   assign rsp_bus_value  = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

[rtl/rgb888_pack_to_rgb565_pixel_writer.sv]
// ----------------------------------------------------------------------------
// rgb888_pack_to_rgb565_pixel_writer
// Unpacks 24-bit pixels from 16-bit words, converts them to RGB565 and writes
// each in-bounds pixel to the display bus as a twelve-word addressed run.
// ----------------------------------------------------------------------------
// A word is taken in any cycle in which no converted pixel is waiting, and
// also in the cycle its last bus word enters the output register. Every third
// word of a group completes nothing; the other two each complete a pixel, and
// an in-bounds pixel holds the single bus-word output register for twelve
// words. The pixel is loaded into the pixel holding register as the word that
// completes it is taken; its first bus word then enters the output register
// when that is free. Register writes belong between pictures, except start_y
// and end_y, which steer the column wrap from the next pixel on.
module rgb888_pack_to_rgb565_pixel_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_halfword,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_command,
   output logic [15:0] rsp_bus_value,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   logic [15:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] held_ff, held_in;
   logic [15:0] cur_x_ff, cur_x_in;
   logic [15:0] cur_y_ff, cur_y_in;
   logic [31:0] pairs_left_ff, pairs_left_in;

   logic        csr_write;
   logic [1:0]  csr_index;
   logic        acc;
   logic [15:0] cx, cy, ny, hw;
   logic [1:0]  ph;
   logic [16:0] span_x, span_y;
   logic [33:0] area;
   logic        reversed, count_nz, live, emit, in_bounds;
   logic [31:0] count;
   logic [15:0] colour_a, colour_b;

   rgbpw_pkg::pixel_type pix;
   logic                 pix_load, pix_ready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      case (csr_index)
         rgbpw_pkg::REG_START_X: csr_prdata = {16'h0000, start_x_ff};
         rgbpw_pkg::REG_START_Y: csr_prdata = {16'h0000, start_y_ff};
         rgbpw_pkg::REG_END_X:   csr_prdata = {16'h0000, end_x_ff};
         rgbpw_pkg::REG_END_Y:   csr_prdata = {16'h0000, end_y_ff};
         default:                csr_prdata = 32'h0000_0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= 16'd0;
         start_y_ff <= 16'd0;
         end_x_ff   <= 16'd479;
         end_y_ff   <= 16'd319;
      end else if (csr_write) begin
         case (csr_index)
            rgbpw_pkg::REG_START_X: start_x_ff <= csr_pwdata[15:0];
            rgbpw_pkg::REG_START_Y: start_y_ff <= csr_pwdata[15:0];
            rgbpw_pkg::REG_END_X:   end_x_ff   <= csr_pwdata[15:0];
            rgbpw_pkg::REG_END_Y:   end_y_ff   <= csr_pwdata[15:0];
            default:                start_x_ff <= start_x_ff;
         endcase
      end
   end

   always_comb begin
      acc = req_valid && req_ready;

      span_x   = {1'b0, end_x_ff} - {1'b0, start_x_ff} + 17'd1;
      span_y   = {1'b0, end_y_ff} - {1'b0, start_y_ff} + 17'd1;
      area     = span_x * span_y;
      reversed = (end_x_ff < start_x_ff) || (end_y_ff < start_y_ff);
      count    = reversed ? 32'd0 : area[32:1];
      count_nz = !reversed && !((end_x_ff == start_x_ff) && (end_y_ff == start_y_ff));

      cx   = req_first ? start_x_ff : cur_x_ff;
      cy   = req_first ? start_y_ff : cur_y_ff;
      ph   = req_first ? PH_FIRST : phase_ff;
      hw   = req_first ? 16'h0000 : held_ff;
      live = req_first ? count_nz : (pairs_left_ff != 32'd0);

      colour_a = {req_halfword[7:3], hw[15:10], hw[7:3]};
      colour_b = {req_halfword[15:11], req_halfword[7:2], hw[15:11]};

      emit      = live && ((ph == PH_SECOND) || (ph == PH_THIRD));
      in_bounds = (cx <= rgbpw_pkg::PANEL_X_LIMIT) && (cy <= rgbpw_pkg::PANEL_Y_LIMIT);
      ny        = cy + 16'd1;

      pix.x      = cx;
      pix.y      = cy;
      pix.colour = (ph == PH_THIRD) ? colour_b : colour_a;
      pix_load   = acc && emit && in_bounds;

      phase_in      = phase_ff;
      held_in       = held_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      pairs_left_in = pairs_left_ff;

      if (acc) begin
         if (req_first) begin
            phase_in      = PH_FIRST;
            held_in       = 16'h0000;
            cur_x_in      = start_x_ff;
            cur_y_in      = start_y_ff;
            pairs_left_in = count;
         end
         if (live) begin
            held_in = req_halfword;
            case (ph)
               PH_SECOND: phase_in = PH_THIRD;
               PH_THIRD: begin
                  phase_in      = PH_FIRST;
                  pairs_left_in = pairs_left_ff - 32'd1;
               end
               default: phase_in = PH_SECOND;
            endcase
            if (emit) begin
               if (ny > end_y_ff) begin
                  cur_x_in = cx + 16'd1;
                  cur_y_in = start_y_ff;
               end else begin
                  cur_x_in = cx;
                  cur_y_in = ny;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         held_ff       <= 16'h0000;
         cur_x_ff      <= 16'h0000;
         cur_y_ff      <= 16'h0000;
         pairs_left_ff <= 32'd0;
      end else begin
         phase_ff      <= phase_in;
         held_ff       <= held_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         pairs_left_ff <= pairs_left_in;
      end
   end

   assign req_ready = pix_ready;

   rgbpw_word_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (pix_load),
      .load_pixel     (pix),
      .load_ready     (pix_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_command (rsp_is_command),
      .rsp_bus_value  (rsp_bus_value),
      .rsp_last       (rsp_last)
   );

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !rsp_is_command)
      else $error("last word of a run marked as command");

   a_command_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_command |->
         (rsp_bus_value == rgbpw_pkg::CMD_COL_ADDR) ||
         (rsp_bus_value == rgbpw_pkg::CMD_ROW_ADDR) ||
         (rsp_bus_value == rgbpw_pkg::CMD_MEM_WRITE))
      else $error("command word carries an unknown code");

   a_pairs_no_rise: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(req_valid && req_ready && req_first) |->
         pairs_left_ff <= $past(pairs_left_ff))
      else $error("pair count rose without a picture start");

endmodule
